### rtl/dual_stepper_ramp_pulser_core_assert.svh
// Assertion macros for the dual stepper ramp pulser.
// Expects clk and arst_n in the scope of use.
`ifndef DUAL_STEPPER_RAMP_PULSER_CORE_ASSERT_SVH
`define DUAL_STEPPER_RAMP_PULSER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DSRP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dsrp assertion failed");
`define DSRP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dsrp assertion failed");
`else
`define DSRP_ASSERT_IMP(lbl, ante, cons)
`define DSRP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/dsrp_pkg.sv
// Types, codes and constants of the dual stepper ramp pulser.
// No dependencies.
`default_nettype none
package dsrp_pkg;

	localparam logic [13:0] IV_MIN      = 14'd500;
	localparam logic [13:0] IV_MAX      = 14'd10000;
	localparam logic [13:0] IV_RESET    = 14'd2000;
	localparam logic [13:0] BEGIN_RESET = 14'd5000;

	localparam logic [2:0] FN_TICK  = 3'd0;
	localparam logic [2:0] FN_CMD   = 3'd1;
	localparam logic [2:0] FN_SET   = 3'd2;
	localparam logic [2:0] FN_RAMP  = 3'd3;
	localparam logic [2:0] FN_SSTOP = 3'd4;

	localparam logic [2:0] CMD_STOP = 3'd0;
	localparam logic [2:0] CMD_FWD  = 3'd1;
	localparam logic [2:0] CMD_BWD  = 3'd2;
	localparam logic [2:0] CMD_CW   = 3'd3;
	localparam logic [2:0] CMD_CCW  = 3'd4;

	localparam logic       REG_ENABLE   = 1'b0;
	localparam logic       REG_RAMP_LEN = 1'b1;

	localparam logic signed [1:0] DIR_IDLE = 2'sb00;
	localparam logic signed [1:0] DIR_FWD  = 2'sb01;
	localparam logic signed [1:0] DIR_REV  = 2'sb11;

	// quotient of the ramp division fits in the interval width
	localparam int DIV_STEPS = 14;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	typedef struct packed {
		logic take;
		logic mul;
		logic step;
		logic fin;
		logic move;
	} ctl_t;

	typedef struct packed {
		logic need_div;
	} sts_t;

	function automatic logic [13:0] clamp_iv(input logic [15:0] v);
		logic [13:0] r;
		if (v < {2'b00, IV_MIN})
			r = IV_MIN;
		else if (v > {2'b00, IV_MAX})
			r = IV_MAX;
		else
			r = v[13:0];
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/dsrp_ctrl.sv
// Sequencer of the dual stepper ramp pulser: handshakes, divide sequencing,
// result staging flags. Depends on dsrp_pkg.
`default_nettype none
module dsrp_ctrl (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  wire          out_stall,
	input  dsrp_pkg::sts_t sts,
	output dsrp_pkg::ctl_t ctl
);
	import dsrp_pkg::*;
	`include "dual_stepper_ramp_pulser_core_assert.svh"

	state_t                 state_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   pend_v_q;
	logic                   out_v_q;
	logic                   out_free;
	logic                   load;

	assign in_stall = !((state_q == ST_IDLE) && !pend_v_q);
	assign out_free = !out_v_q || !out_stall;

	always_comb begin
		ctl.take = in_valid && !in_stall;
		ctl.mul  = (state_q == ST_MUL);
		ctl.step = (state_q == ST_DIV);
		ctl.fin  = (state_q == ST_FIN);
		ctl.move = pend_v_q && out_free;
	end

	assign load      = (ctl.take && !sts.need_div) || ctl.fin;
	assign out_valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.take && sts.need_div)
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
						state_q <= ST_FIN;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_FIN: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (load)
				pend_v_q <= 1'b1;
			else if (ctl.move)
				pend_v_q <= 1'b0;
			if (ctl.move)
				out_v_q <= 1'b1;
			else if (!out_stall)
				out_v_q <= 1'b0;
		end
	end

	`DSRP_ASSERT_IMP(a_busy_no_pend, state_q != ST_IDLE, !pend_v_q)
	`DSRP_ASSERT_NXT(a_mul_to_div, state_q == ST_MUL, state_q == ST_DIV)
	`DSRP_ASSERT_NXT(a_fin_loads, state_q == ST_FIN, pend_v_q)

endmodule
`default_nettype wire

### rtl/dsrp_datapath.sv
// Datapath of the dual stepper ramp pulser: motion state, tick timer, ramp
// multiply and divide, result staging. Depends on dsrp_pkg.
`default_nettype none
module dsrp_datapath (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire                cfg_index,
	input  wire  [15:0]        cfg_data,
	input  wire  [2:0]         func,
	input  wire  [2:0]         command,
	input  wire  [15:0]        interval,
	input  dsrp_pkg::ctl_t     ctl,
	output dsrp_pkg::sts_t     sts,
	output logic               step_one,
	output logic signed [1:0]  dir_one,
	output logic               step_two,
	output logic signed [1:0]  dir_two,
	output logic               coils_off,
	output logic signed [31:0] position,
	output logic [13:0]        interval_now,
	output logic               running,
	output logic               ramping
);
	import dsrp_pkg::*;
	`include "dual_stepper_ramp_pulser_core_assert.svh"

	logic               enable_q;
	logic [15:0]        rlen_q;

	logic [13:0]        interval_q, begin_q, end_q, tick_q;
	logic [15:0]        pos_q;
	logic               active_q, stop_pend_q;
	logic [2:0]         motion_q;
	logic signed [1:0]  dir1_q, dir2_q;
	logic [31:0]        total_q;

	logic [13:0]        interval_nx, begin_nx, end_nx, tick_nx;
	logic [15:0]        pos_nx;
	logic               active_nx, stop_pend_nx;
	logic [2:0]         motion_nx;
	logic signed [1:0]  dir1_nx, dir2_nx;
	logic [31:0]        total_nx;
	logic               s1, s2, coils, need_div;

	logic [16:0]        k;
	logic [13:0]        tgt;

	logic               dec;
	logic [13:0]        diff;
	logic [29:0]        prod;
	logic [15:0]        rem_q;
	logic [13:0]        quo_q;
	logic [16:0]        r2, r2_sub;
	logic               ge;
	logic [13:0]        ramp_iv;

	logic               pend_s1_q, pend_s2_q, pend_coils_q, pend_run_q, pend_ramp_q;
	logic signed [1:0]  pend_dir1_q, pend_dir2_q;
	logic [31:0]        pend_total_q;
	logic [13:0]        pend_interval_q;

	logic               out_s1_q, out_s2_q, out_coils_q, out_run_q, out_ramp_q;
	logic signed [1:0]  out_dir1_q, out_dir2_q;
	logic [31:0]        out_total_q;
	logic [13:0]        out_interval_q;

	assign k   = {1'b0, pos_q} + 17'd1;
	assign tgt = clamp_iv(interval);

	always_comb begin
		interval_nx  = interval_q;
		begin_nx     = begin_q;
		end_nx       = end_q;
		tick_nx      = tick_q;
		pos_nx       = pos_q;
		active_nx    = active_q;
		stop_pend_nx = stop_pend_q;
		motion_nx    = motion_q;
		dir1_nx      = dir1_q;
		dir2_nx      = dir2_q;
		total_nx     = total_q;
		s1           = 1'b0;
		s2           = 1'b0;
		coils        = 1'b0;
		need_div     = 1'b0;
		case (func)
			FN_TICK: begin
				if (enable_q) begin
					if ({1'b0, tick_q} + 15'd1 >= {1'b0, interval_q}) begin
						tick_nx = '0;
						if (active_q) begin
							if (k >= {1'b0, rlen_q}) begin
								interval_nx = end_q;
								active_nx   = 1'b0;
								pos_nx      = '0;
								if (stop_pend_q) begin
									stop_pend_nx = 1'b0;
									motion_nx    = CMD_STOP;
									dir1_nx      = DIR_IDLE;
									dir2_nx      = DIR_IDLE;
								end
							end else begin
								pos_nx   = k[15:0];
								need_div = 1'b1;
							end
						end
						if (motion_nx != CMD_STOP) begin
							s1       = (dir1_nx != DIR_IDLE);
							s2       = (dir2_nx != DIR_IDLE);
							total_nx = total_q + {{30{dir1_nx[1]}}, dir1_nx};
						end
					end else begin
						tick_nx = tick_q + 14'd1;
					end
				end
			end
			FN_CMD: begin
				unique case (command)
					CMD_STOP: begin
						motion_nx = CMD_STOP;
						dir1_nx   = DIR_IDLE;
						dir2_nx   = DIR_IDLE;
						coils     = 1'b1;
					end
					CMD_FWD: begin
						motion_nx = CMD_FWD;
						dir1_nx   = DIR_FWD;
						dir2_nx   = DIR_FWD;
					end
					CMD_BWD: begin
						motion_nx = CMD_BWD;
						dir1_nx   = DIR_REV;
						dir2_nx   = DIR_REV;
					end
					CMD_CW: begin
						motion_nx = CMD_CW;
						dir1_nx   = DIR_FWD;
						dir2_nx   = DIR_REV;
					end
					CMD_CCW: begin
						motion_nx = CMD_CCW;
						dir1_nx   = DIR_REV;
						dir2_nx   = DIR_FWD;
					end
					default: ;
				endcase
			end
			FN_SET: interval_nx = tgt;
			FN_RAMP: begin
				if (rlen_q == '0) begin
					interval_nx = tgt;
				end else begin
					begin_nx = interval_q;
					end_nx   = tgt;
					pos_nx   = '0;
					if (interval_q != tgt)
						active_nx = 1'b1;
				end
			end
			FN_SSTOP: begin
				if (rlen_q == '0 || motion_q == CMD_STOP) begin
					motion_nx = CMD_STOP;
					dir1_nx   = DIR_IDLE;
					dir2_nx   = DIR_IDLE;
					coils     = 1'b1;
				end else begin
					stop_pend_nx = 1'b1;
					begin_nx     = interval_q;
					end_nx       = IV_MAX;
					pos_nx       = '0;
					active_nx    = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign sts.need_div = need_div;

	// ramp offset = |end - begin| * pos / ramp_length
	assign dec     = end_q < begin_q;
	assign diff    = dec ? (begin_q - end_q) : (end_q - begin_q);
	assign prod    = {16'b0, diff} * {14'b0, pos_q};
	assign r2      = {rem_q, quo_q[13]};
	assign ge      = r2 >= {1'b0, rlen_q};
	assign r2_sub  = r2 - {1'b0, rlen_q};
	assign ramp_iv = dec ? (begin_q - quo_q) : (begin_q + quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			rlen_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE:   enable_q <= cfg_data[0];
				REG_RAMP_LEN: rlen_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= IV_RESET;
			begin_q     <= BEGIN_RESET;
			end_q       <= IV_RESET;
			tick_q      <= '0;
			pos_q       <= '0;
			active_q    <= 1'b0;
			stop_pend_q <= 1'b0;
			motion_q    <= CMD_STOP;
			dir1_q      <= DIR_IDLE;
			dir2_q      <= DIR_IDLE;
			total_q     <= '0;
		end else if (ctl.take) begin
			interval_q  <= interval_nx;
			begin_q     <= begin_nx;
			end_q       <= end_nx;
			tick_q      <= tick_nx;
			pos_q       <= pos_nx;
			active_q    <= active_nx;
			stop_pend_q <= stop_pend_nx;
			motion_q    <= motion_nx;
			dir1_q      <= dir1_nx;
			dir2_q      <= dir2_nx;
			total_q     <= total_nx;
		end else if (ctl.fin) begin
			interval_q <= ramp_iv;
		end
	end

	// top bits of the product are below ramp_length, so 14 steps give the quotient
	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			rem_q <= prod[29:14];
			quo_q <= prod[13:0];
		end else if (ctl.step) begin
			rem_q <= ge ? r2_sub[15:0] : r2[15:0];
			quo_q <= {quo_q[12:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			pend_s1_q       <= s1;
			pend_s2_q       <= s2;
			pend_coils_q    <= coils;
			pend_dir1_q     <= dir1_nx;
			pend_dir2_q     <= dir2_nx;
			pend_total_q    <= total_nx;
			pend_interval_q <= interval_nx;
			pend_run_q      <= enable_q && (motion_nx != CMD_STOP);
			pend_ramp_q     <= active_nx;
		end else if (ctl.fin) begin
			pend_interval_q <= ramp_iv;
		end
		if (ctl.move) begin
			out_s1_q       <= pend_s1_q;
			out_s2_q       <= pend_s2_q;
			out_coils_q    <= pend_coils_q;
			out_dir1_q     <= pend_dir1_q;
			out_dir2_q     <= pend_dir2_q;
			out_total_q    <= pend_total_q;
			out_interval_q <= pend_interval_q;
			out_run_q      <= pend_run_q;
			out_ramp_q     <= pend_ramp_q;
		end
	end

	assign step_one     = out_s1_q;
	assign dir_one      = out_dir1_q;
	assign step_two     = out_s2_q;
	assign dir_two      = out_dir2_q;
	assign coils_off    = out_coils_q;
	assign position     = out_total_q;
	assign interval_now = out_interval_q;
	assign running      = out_run_q;
	assign ramping      = out_ramp_q;

	`DSRP_ASSERT_IMP(a_iv_range, 1'b1, interval_q >= IV_MIN && interval_q <= IV_MAX)
	`DSRP_ASSERT_IMP(a_rem_below_len, ctl.step, rem_q < rlen_q)
	`DSRP_ASSERT_NXT(a_fin_iv_match, ctl.fin, interval_q == pend_interval_q)

endmodule
`default_nettype wire

### rtl/dual_stepper_ramp_pulser_core.sv
// Dual stepper ramp pulser, top level.
// Each result passes a pending register and then the output register; an alarm that
// advances a ramp first runs one multiply, 14 divide steps and a load (MUL, DIV, FIN).
// A new item is taken only once the pending register is empty and no ramp step is being
// computed; while a result waits under out_stall, a pending result cannot move on.
// Reset: arst_n asynchronous, active low; state returns to its power-up values.
`default_nettype none
module dual_stepper_ramp_pulser_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire                cfg_index,
	input  wire  [15:0]        cfg_data,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  [2:0]         func,
	input  wire  [2:0]         command,
	input  wire  [15:0]        interval,
	output logic               out_valid,
	input  wire                out_stall,
	output logic               step_one,
	output logic signed [1:0]  dir_one,
	output logic               step_two,
	output logic signed [1:0]  dir_two,
	output logic               coils_off,
	output logic signed [31:0] position,
	output logic [13:0]        interval_now,
	output logic               running,
	output logic               ramping
);
	import dsrp_pkg::*;

	ctl_t ctl;
	sts_t sts;

	dsrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	dsrp_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.func         (func),
		.command      (command),
		.interval     (interval),
		.ctl          (ctl),
		.sts          (sts),
		.step_one     (step_one),
		.dir_one      (dir_one),
		.step_two     (step_two),
		.dir_two      (dir_two),
		.coils_off    (coils_off),
		.position     (position),
		.interval_now (interval_now),
		.running      (running),
		.ramping      (ramping)
	);

endmodule
`default_nettype wire

### dv/pulser_checker.sv
// Result checker for dual_stepper_ramp_pulser_core: follows register writes and
// transfers on both channels, predicts every result and compares it field by field.
// Depends on dsrp_pkg.
module pulser_checker
	import dsrp_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire                cfg_index,
	input  wire  [15:0]        cfg_data,
	input  wire                in_valid,
	input  wire                in_stall,
	input  wire  [2:0]         func,
	input  wire  [2:0]         command,
	input  wire  [15:0]        interval,
	input  wire                out_valid,
	input  wire                out_stall,
	input  wire                step_one,
	input  wire signed [1:0]   dir_one,
	input  wire                step_two,
	input  wire signed [1:0]   dir_two,
	input  wire                coils_off,
	input  wire signed [31:0]  position,
	input  wire  [13:0]        interval_now,
	input  wire                running,
	input  wire                ramping,
	output int                 faults,
	output int                 outstanding
);

	typedef struct packed {
		logic               step_one;
		logic signed [1:0]  dir_one;
		logic               step_two;
		logic signed [1:0]  dir_two;
		logic               coils_off;
		logic signed [31:0] position;
		logic [13:0]        interval_now;
		logic               running;
		logic               ramping;
	} motor_report_t;

	motor_report_t reports_due[$];

	logic               en;
	logic [15:0]        rlen;
	logic [13:0]        iv_cur, ramp_from, ramp_to, ticks;
	logic [15:0]        ramp_idx;
	logic               ramp_on, stop_armed;
	logic [2:0]         motion;
	logic signed [1:0]  dir1, dir2;
	logic signed [31:0] steps;

	initial begin
		faults = 0;
		outstanding = 0;
	end

	function automatic logic [13:0] fit_interval(logic [15:0] v);
		if (v > 16'(IV_MAX))
			return IV_MAX;
		return (v < 16'(IV_MIN)) ? IV_MIN : v[13:0];
	endfunction

	function automatic void halt_motion();
		motion = CMD_STOP;
		dir1 = DIR_IDLE;
		dir2 = DIR_IDLE;
	endfunction

	function automatic void step_ramp();
		int unsigned k, from_v, to_v;
		k = ramp_idx + 1;
		from_v = ramp_from;
		to_v = ramp_to;
		if (k >= rlen) begin
			iv_cur = ramp_to;
			ramp_on = 1'b0;
			ramp_idx = '0;
			if (stop_armed) begin
				stop_armed = 1'b0;
				halt_motion();
			end
		end else begin
			ramp_idx = k[15:0];
			if (to_v < from_v)
				iv_cur = 14'(from_v - (from_v - to_v) * k / rlen);
			else
				iv_cur = 14'(from_v + (to_v - from_v) * k / rlen);
		end
	endfunction

	function automatic motor_report_t advance_motors(logic [2:0] fn, logic [2:0] cmd,
			logic [15:0] req);
		motor_report_t r;
		logic [13:0] target;
		r = '0;
		case (fn)
		FN_TICK: begin
			if (en) begin
				if (int'(ticks) + 1 >= int'(iv_cur)) begin
					ticks = '0;
					if (ramp_on)
						step_ramp();
					if (motion != CMD_STOP) begin
						r.step_one = (dir1 != DIR_IDLE);
						r.step_two = (dir2 != DIR_IDLE);
						steps = steps + dir1;
					end
				end else begin
					ticks = ticks + 14'd1;
				end
			end
		end
		FN_CMD: begin
			case (cmd)
			CMD_STOP: begin
				halt_motion();
				r.coils_off = 1'b1;
			end
			CMD_FWD: begin
				motion = CMD_FWD;
				dir1 = DIR_FWD;
				dir2 = DIR_FWD;
			end
			CMD_BWD: begin
				motion = CMD_BWD;
				dir1 = DIR_REV;
				dir2 = DIR_REV;
			end
			CMD_CW: begin
				motion = CMD_CW;
				dir1 = DIR_FWD;
				dir2 = DIR_REV;
			end
			CMD_CCW: begin
				motion = CMD_CCW;
				dir1 = DIR_REV;
				dir2 = DIR_FWD;
			end
			default: ;
			endcase
		end
		FN_SET: iv_cur = fit_interval(req);
		FN_RAMP: begin
			target = fit_interval(req);
			if (rlen == 0) begin
				iv_cur = target;
			end else begin
				ramp_from = iv_cur;
				ramp_to = target;
				ramp_idx = '0;
				if (iv_cur != target)
					ramp_on = 1'b1;
			end
		end
		FN_SSTOP: begin
			if (rlen == 0 || motion == CMD_STOP) begin
				halt_motion();
				r.coils_off = 1'b1;
			end else begin
				stop_armed = 1'b1;
				ramp_from = iv_cur;
				ramp_to = IV_MAX;
				ramp_idx = '0;
				ramp_on = 1'b1;
			end
		end
		default: ;
		endcase
		r.dir_one = dir1;
		r.dir_two = dir2;
		r.position = steps;
		r.interval_now = iv_cur;
		r.running = en && (motion != CMD_STOP);
		r.ramping = ramp_on;
		return r;
	endfunction

	task automatic match(string name, longint want_v, longint got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, actual %0d", name, want_v, got_v);
			faults++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		motor_report_t got, want;
		if (!arst_n) begin
			en = 1'b0;
			rlen = '0;
			iv_cur = IV_RESET;
			ramp_from = BEGIN_RESET;
			ramp_to = IV_RESET;
			ramp_idx = '0;
			ramp_on = 1'b0;
			stop_armed = 1'b0;
			motion = CMD_STOP;
			dir1 = DIR_IDLE;
			dir2 = DIR_IDLE;
			steps = '0;
			ticks = '0;
			reports_due.delete();
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ENABLE)
					en = cfg_data[0];
				else
					rlen = cfg_data;
			end
			if (in_valid && !in_stall)
				reports_due.push_back(advance_motors(func, command, interval));
			if (out_valid && !out_stall) begin
				got = {step_one, dir_one, step_two, dir_two, coils_off, position,
					interval_now, running, ramping};
				if (reports_due.size() == 0) begin
					$error("result transfer with no expectation pending");
					faults++;
				end else begin
					want = reports_due.pop_front();
					match("step_one", want.step_one, got.step_one);
					match("dir_one", $signed(want.dir_one), $signed(got.dir_one));
					match("step_two", want.step_two, got.step_two);
					match("dir_two", $signed(want.dir_two), $signed(got.dir_two));
					match("coils_off", want.coils_off, got.coils_off);
					match("position", $signed(want.position), $signed(got.position));
					match("interval_now", want.interval_now, got.interval_now);
					match("running", want.running, got.running);
					match("ramping", want.ramping, got.ramping);
				end
			end
			outstanding = reports_due.size();
		end
	end

endmodule

### dv/testbench.sv
// Top of the dual_stepper_ramp_pulser_core bench: clock, reset, register setup,
// directed and random items with random gaps and stalls, watchdog and verdict.
// Depends on dsrp_pkg, dual_stepper_ramp_pulser_core and pulser_checker.
module testbench;
	import dsrp_pkg::*;

	localparam logic [2:0] FN_LAST     = 3'd7;
	localparam logic [2:0] CMD_LAST    = 3'd7;
	localparam int         PHASES      = 8;
	localparam int         PHASE_ITEMS = 8;
	localparam int         HOLD_CYCLES = 400;
	localparam int         IDLE_LIMIT  = 2000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_index = REG_ENABLE;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic [2:0]         func = FN_TICK;
	logic [2:0]         command = CMD_STOP;
	logic [15:0]        interval = '0;
	logic               out_stall = 1'b0;
	wire                in_stall, out_valid;
	wire                step_one, step_two, coils_off, running, ramping;
	wire signed [1:0]   dir_one, dir_two;
	wire signed [31:0]  position;
	wire [13:0]         interval_now;
	int                 faults, outstanding;
	int                 idle_cycles = 0;
	bit                 eager = 1'b0;
	bit                 hold_req = 1'b0;

	dual_stepper_ramp_pulser_core dut (.*);

	pulser_checker u_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("dual_stepper_ramp_pulser_core verification failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic int pick_stall();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_burst();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(0, 3);
		return $urandom_range(4, 12);
	endfunction

	function automatic logic [15:0] pick_interval();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return 16'($urandom_range(0, 1200));
		if (r < 80)
			return 16'($urandom_range(500, 10000));
		if (r < 90)
			return 16'($urandom);
		case ($urandom_range(0, 7))
		0: return 16'd0;
		1: return 16'd499;
		2: return 16'd500;
		3: return 16'd501;
		4: return 16'd9999;
		5: return 16'd10000;
		6: return 16'd10001;
		default: return 16'hffff;
		endcase
	endfunction

	function automatic logic [2:0] pick_command();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 3'($urandom_range(CMD_CCW + 1, CMD_LAST));
		if (r < 25)
			return CMD_STOP;
		return 3'($urandom_range(CMD_FWD, CMD_CCW));
	endfunction

	// holds the payload until the transfer happens
	task automatic offer(logic [2:0] fn, logic [2:0] cmd, logic [15:0] iv);
		int gap;
		gap = eager ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		command <= cmd;
		interval <= iv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic tick_burst(int n);
		repeat (n) offer(FN_TICK, 3'($urandom), 16'($urandom));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic set_regs(logic en, logic [15:0] len);
		cfg_we <= 1'b1;
		cfg_index <= REG_ENABLE;
		cfg_data <= {15'($urandom), en};
		@(posedge clk);
		cfg_index <= REG_RAMP_LEN;
		cfg_data <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			offer(FN_CMD, pick_command(), 16'($urandom));
		else if (r < 50)
			offer(FN_SET, 3'($urandom), pick_interval());
		else if (r < 75)
			offer(FN_RAMP, 3'($urandom), pick_interval());
		else if (r < 87)
			offer(FN_SSTOP, 3'($urandom), 16'($urandom));
		else if (r < 92)
			offer(3'($urandom_range(FN_SSTOP + 1, FN_LAST)), 3'($urandom), 16'($urandom));
		else
			offer(FN_TICK, 3'($urandom), 16'($urandom));
		tick_burst(pick_burst());
	endtask

	// receiver: random ready and stall runs, one long hold on request
	initial begin
		int run;
		forever begin
			out_stall <= 1'b0;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 20);
			repeat (run) begin
				@(posedge clk);
				if (hold_req)
					break;
			end
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!eager) begin
				out_stall <= 1'b1;
				repeat (pick_stall()) @(posedge clk);
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// timer disabled, no ramping
		set_regs(1'b0, 16'd0);
		offer(FN_TICK, CMD_LAST, 16'hffff);
		offer(FN_LAST, CMD_FWD, 16'd1234);
		offer(FN_CMD, CMD_FWD, '0);
		offer(FN_CMD, CMD_LAST, '0);
		offer(FN_SET, CMD_STOP, 16'd0);
		offer(FN_SET, CMD_STOP, 16'hffff);
		offer(FN_SET, CMD_STOP, 16'd10001);
		offer(FN_SET, CMD_STOP, 16'd501);
		offer(FN_RAMP, CMD_STOP, 16'd700);
		offer(FN_SSTOP, CMD_STOP, '0);
		offer(FN_CMD, CMD_BWD, '0);
		offer(FN_CMD, CMD_CW, '0);
		offer(FN_CMD, CMD_CCW, '0);
		offer(FN_CMD, CMD_STOP, '0);
		settle();

		set_regs(1'b1, 16'd4);
		offer(FN_CMD, CMD_FWD, '0);
		offer(FN_SET, CMD_STOP, 16'd10000);
		tick_burst(520);
		// drop below the running count: alarm on the next tick
		offer(FN_SET, CMD_STOP, 16'd499);
		tick_burst(1);
		offer(FN_CMD, CMD_CW, '0);
		offer(FN_RAMP, CMD_STOP, 16'd520);
		offer(FN_RAMP, CMD_STOP, 16'd520);
		offer(FN_SET, CMD_STOP, 16'd800);
		offer(FN_RAMP, CMD_STOP, 16'd800);
		tick_burst(10);
		settle();

		// smooth stop overtaken by a new target, two alarms finish the ramp
		set_regs(1'b1, 16'd2);
		offer(FN_CMD, CMD_CCW, '0);
		offer(FN_SET, CMD_STOP, 16'd500);
		offer(FN_SSTOP, CMD_STOP, '0);
		offer(FN_RAMP, CMD_STOP, 16'd600);
		tick_burst(1060);
		offer(FN_SSTOP, CMD_STOP, '0);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
			0: set_regs(1'b1, 16'd3);
			1: set_regs(1'b1, 16'd0);
			2: set_regs(1'b1, 16'd1);
			3: set_regs(1'b0, 16'd2);
			4: set_regs(1'b1, 16'hffff);
			5: set_regs(1'b1, 16'd2);
			6: set_regs(1'b1, 16'd6);
			default: set_regs(1'b1, 16'd0);
			endcase
			eager = (p == 2 || p == 6);
			if (p == 4) begin
				hold_req = 1'b1;
				tick_burst(40);
			end
			repeat (PHASE_ITEMS) random_item();
		end

		settle();
		repeat (40) @(posedge clk);
		if (faults == 0 && outstanding == 0)
			$display("dual_stepper_ramp_pulser_core verification clean");
		else
			$display("dual_stepper_ramp_pulser_core verification failed");
		$finish;
	end

endmodule
